/* rtl/wta_pkg.sv */
package wta_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W = 7;
    localparam int APB_DATA_W = 32;
    localparam int ADDR_W = 3;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(50);

    // Register indexes (byte address divided by four)
    localparam logic [REG_IDX_W-1:0] REG_WINDOW = REG_IDX_W'(0);

    // Item kinds carried on the input tuser
    localparam logic ACTION_PUSH = 1'b0;
    localparam logic ACTION_FINISH = 1'b1;

    // Result status carried on the output tuser
    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_SHORT = 1'b1;

    typedef struct packed {
        logic              action;
        logic [DATA_W-1:0] sample;
    } wta_item_t;

endpackage

/* rtl/window_tail_average_top.sv */
// Moving average over the last W signed Q16.16 samples. Each input transfer
// carries a kind on s_axis_tuser: push (tdata is the sample) or finish. A
// push produces no result; a finish produces one result transfer carrying
// the mean of the last W samples on m_axis_tdata (truncated toward zero) with
// status 0 on m_axis_tuser, or average 0 with status 1 if fewer than W
// samples arrived since the last finish. Every finish starts a new run.
// W is window_length at byte address 0 of the APB port (reset 50); 0 acts
// as 1 and values above MAX_WINDOW act as MAX_WINDOW, and writing it also
// starts a new run. Write it only while the block is idle.
// Rate: pushes stream at one per cycle while no finish waits at the head of
// the input queue. Every transfer is registered in the two-entry input queue
// before the back end acts on it. A finish waits for the two-stage sum
// pipeline to drain and for the previous result to be taken; with enough
// samples it then runs the shift-subtract divider, one bit of the running
// sum per cycle, and the quotient is registered for output; otherwise the
// short status appears in the next cycle. Pushes keep flowing during a
// division. The sample ring is a plain RAM; it
// needs no clearing after reset because only slots written in the current
// run are read back.
module window_tail_average_top #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // [31:0] sample
    input  logic                          s_axis_tuser,  // [0] action
    // Result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,  // [31:0] average
    output logic                          m_axis_tuser,  // [0] status
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wta_pkg::ADDR_W-1:0]     paddr,
    input  logic [wta_pkg::APB_DATA_W-1:0] pwdata,
    output logic [wta_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);

    import wta_pkg::*;

    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int CW = (WW > CFG_W) ? WW : CFG_W;

    logic [CFG_W-1:0]     window_reg;
    logic [CFG_W-1:0]     window_next;
    logic [CW-1:0]        win_ext;
    logic [WW-1:0]        win_eff;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;
    logic                 clear_run;
    logic                 q_valid;
    logic                 q_pop;
    wta_item_t            q_item;

    // Register file: one register, written on the APB access phase
    assign pready = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign clear_run = cfg_write && (reg_idx == REG_WINDOW);

    always_comb
    begin
        window_next = window_reg;
        if (clear_run)
        begin
            window_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_WINDOW: prdata = APB_DATA_W'(window_reg);
            default:    prdata = '0;
        endcase
    end

    // Clamp the programmed window into 1..MAX_WINDOW
    assign win_ext = CW'(window_reg);

    always_comb
    begin
        if (win_ext == '0)
        begin
            win_eff = WW'(1);
        end
        else if (win_ext > CW'(MAX_WINDOW))
        begin
            win_eff = WW'(MAX_WINDOW);
        end
        else
        begin
            win_eff = WW'(win_ext);
        end
    end

    // Front: take input transfers into a two-entry queue
    wta_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    // Back: ring, running sum, divider and result register
    wta_back #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .window       (win_eff),
        .clear_run    (clear_run),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

endmodule

/* rtl/wta_ram.sv */
module wta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents when the same address is written
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/wta_front.sv */
module wta_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,  // [31:0] sample
    input  logic                 s_axis_tuser,  // [0] action
    output logic                 q_valid,
    output wta_pkg::wta_item_t   q_item,
    input  logic                 q_pop
);

    import wta_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    wta_item_t        ent_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push;
    logic             pop;

    assign s_axis_tready = (cnt_reg != CNT_W'(DEPTH));
    assign push = s_axis_tvalid && s_axis_tready;
    assign q_valid = (cnt_reg != '0);
    assign pop = q_pop && q_valid;
    assign q_item = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= '{action: s_axis_tuser, sample: s_axis_tdata};
        end
    end

endmodule

/* rtl/wta_div.sv */
module wta_div #(
    parameter int SUM_W = 38,
    parameter int WW = 7
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [SUM_W-1:0]   dividend,
    input  logic [WW-1:0]             divisor,
    output logic                      busy,
    output logic                      done,
    output logic [wta_pkg::DATA_W-1:0] quotient
);

    import wta_pkg::*;

    localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              neg_reg;
    logic [WW-1:0]     dvs_reg;
    logic [WW-1:0]     rem_reg;
    logic [WW-1:0]     rem_next;
    logic [SUM_W-1:0]  quo_reg;
    logic [SUM_W-1:0]  quo_next;
    logic [WW:0]       trial;
    logic              take;
    logic [SUM_W-1:0]  signed_q;

    // One quotient bit per cycle, restoring on the magnitude
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign take = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = CNT_W'(SUM_W - 1);
            rem_next = '0;
            quo_next = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
        end
        else if (busy_reg)
        begin
            rem_next = take ? WW'(trial - {1'b0, dvs_reg}) : WW'(trial);
            quo_next = {quo_reg[SUM_W-2:0], take};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            dvs_reg <= divisor;
        end
    end

    assign signed_q = neg_reg ? -quo_reg : quo_reg;
    assign quotient = signed_q[DATA_W-1:0];
    assign busy = busy_reg || done_reg;
    assign done = done_reg;

endmodule

/* rtl/wta_back.sv */
module wta_back #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [$clog2(MAX_WINDOW + 1)-1:0]    window,
    input  logic                                 clear_run,
    input  logic                                 q_valid,
    input  wta_pkg::wta_item_t                   q_item,
    output logic                                 q_pop,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [31:0]                          m_axis_tdata,  // [31:0] average
    output logic                                 m_axis_tuser   // [0] status
);

    import wta_pkg::*;

    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W = DATA_W + SLOT_W;

    logic [SLOT_W-1:0]       slot_reg;
    logic [SLOT_W-1:0]       slot_next;
    logic [WW-1:0]           slot_inc;
    logic [WW-1:0]           fill_reg;
    logic [WW-1:0]           fill_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic                    s1_valid_reg;
    logic [DATA_W-1:0]       s1_sample_reg;
    logic                    s1_sub_reg;
    logic                    s2_valid_reg;
    logic signed [DATA_W:0]  s2_delta_reg;
    logic signed [DATA_W:0]  delta;
    logic [DATA_W-1:0]       ring_rdata;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [DATA_W-1:0]       out_avg_reg;
    logic                    out_status_reg;
    logic                    full;
    logic                    is_push;
    logic                    finish_ok;
    logic                    push_go;
    logic                    fin_go;
    logic                    short_go;
    logic                    div_start;
    logic                    div_busy;
    logic                    div_done;
    logic [DATA_W-1:0]       div_q;

    assign full = (fill_reg >= window);
    assign is_push = (q_item.action == ACTION_PUSH);
    // A finish waits for the sum pipeline to drain, an idle divider and a free result slot
    assign finish_ok = !s1_valid_reg && !s2_valid_reg && !div_busy && !out_valid_reg;
    assign q_pop = q_valid && (is_push || finish_ok);
    assign push_go = q_pop && is_push;
    assign fin_go = q_pop && !is_push;
    assign short_go = fin_go && !full;
    assign div_start = fin_go && full;

    wta_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MAX_WINDOW)
    ) u_ring (
        .clk  (clk),
        .we   (push_go),
        .waddr(slot_reg),
        .wdata(q_item.sample),
        .raddr(slot_reg),
        .rdata(ring_rdata)
    );

    // The RAM returns the old ring value while the sample that replaces it sits in stage 1
    assign delta = $signed({s1_sample_reg[DATA_W-1], s1_sample_reg})
                 - (s1_sub_reg ? $signed({ring_rdata[DATA_W-1], ring_rdata})
                               : $signed({(DATA_W + 1){1'b0}}));

    assign slot_inc = WW'(slot_reg) + WW'(1);

    always_comb
    begin
        slot_next = slot_reg;
        fill_next = fill_reg;
        sum_next = sum_reg;
        if (s2_valid_reg)
        begin
            sum_next = sum_reg + SUM_W'(s2_delta_reg);
        end
        if (push_go)
        begin
            slot_next = (slot_inc == window) ? '0 : SLOT_W'(slot_inc);
            fill_next = full ? fill_reg : fill_reg + WW'(1);
        end
        if (fin_go || clear_run)
        begin
            slot_next = '0;
            fill_next = '0;
            sum_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (short_go || div_done)
        begin
            out_valid_next = 1'b1;
        end
    end

    wta_div #(
        .SUM_W(SUM_W),
        .WW   (WW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(sum_reg),
        .divisor (window),
        .busy    (div_busy),
        .done    (div_done),
        .quotient(div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            fill_reg <= '0;
            sum_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg <= slot_next;
            fill_reg <= fill_next;
            sum_reg <= sum_next;
            s1_valid_reg <= push_go;
            s2_valid_reg <= s1_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sample_reg <= q_item.sample;
        s1_sub_reg <= full;
        s2_delta_reg <= delta;
        if (short_go)
        begin
            out_avg_reg <= '0;
            out_status_reg <= STATUS_SHORT;
        end
        else if (div_done)
        begin
            out_avg_reg <= div_q;
            out_status_reg <= STATUS_OK;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_avg_reg;
    assign m_axis_tuser = out_status_reg;

endmodule

/* rtl/wta_checker.sv */
module wta_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [31:0]                   m_axis_tdata,
    input logic                          m_axis_tuser,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [wta_pkg::ADDR_W-1:0]     paddr,
    input logic [wta_pkg::APB_DATA_W-1:0] pwdata,
    input logic [wta_pkg::APB_DATA_W-1:0] prdata,
    input logic                          pready
);

    import wta_pkg::*;

    // Hold a stalled result transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // A short run reports a zero average
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == STATUS_SHORT)) |-> (m_axis_tdata == '0))
        else $error("short status with nonzero average");

    // Written window reads back in the next cycle
    a_window_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == REG_WINDOW))
        ##1 (paddr[ADDR_W-1:2] == REG_WINDOW) |->
            (prdata == APB_DATA_W'($past(pwdata[CFG_W-1:0]))))
        else $error("window register readback mismatch");

    // No result appears in the cycle after reset
    a_no_result_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result valid straight out of reset");

endmodule

bind window_tail_average_top wta_checker u_wta_checker (.*);

/* dv/tb_window_tail_average_top.sv */
`timescale 1ns / 1ps

module tb_window_tail_average_top;
    import wta_pkg::*;

    localparam int MAX_WINDOW   = 64;
    localparam int RESET_CYCLES = 5;
    // Covers the sum pipeline plus a full-width division and the output stage
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 320;
    localparam int RANDOM_MEANS = 30;
    localparam int WINDOW_KINDS = 12;

    typedef struct packed {
        logic [DATA_W-1:0] average;
        logic              status;
    } mean_result_t;

    // Tracks the window contents and queues the result each finish is due to give.
    class window_mean_tracker;
        logic [CFG_W-1:0] window_reg;
        longint           ring [MAX_WINDOW];
        int unsigned      slot;
        int unsigned      fill;
        longint           sum;  // stays within 38 bits signed
        mean_result_t     means_due [$];
        int unsigned      errors;

        function new();
            window_reg = WINDOW_RESET;
            errors     = 0;
            restart();
        endfunction

        function void restart();
            slot = 0;
            fill = 0;
            sum  = 0;
        endfunction

        // Clamp the register: zero acts as one, anything above the ring size as the ring size.
        function int unsigned span();
            if (window_reg == '0)
                return 1;
            if (window_reg > MAX_WINDOW)
                return MAX_WINDOW;
            return window_reg;
        endfunction

        function void set_window(logic [CFG_W-1:0] value);
            window_reg = value;
            restart();
        endfunction

        function void accept_item(logic action, logic [DATA_W-1:0] sample);
            int unsigned  w;
            longint       value;
            mean_result_t r;
            w = span();
            if (action == ACTION_PUSH)
            begin
                value = longint'($signed(sample));
                slot  = slot % w;
                if (fill >= w)
                    sum -= ring[slot];
                else
                    fill++;
                ring[slot] = value;
                sum       += value;
                slot       = (slot + 1) % w;
            end
            else
            begin
                if (fill < w)
                begin
                    r.average = '0;
                    r.status  = STATUS_SHORT;
                end
                else
                begin
                    r.average = DATA_W'(sum / longint'(w));
                    r.status  = STATUS_OK;
                end
                means_due.push_back(r);
                restart();
            end
        endfunction

        function void check_mean(logic [DATA_W-1:0] average, logic status);
            mean_result_t want;
            if (means_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, average %h status %b", $time, average, status);
                return;
            end
            want = means_due.pop_front();
            if (average !== want.average)
            begin
                errors++;
                $display("%0t: average expected %h actual %h", $time, want.average, average);
            end
            if (status !== want.status)
            begin
                errors++;
                $display("%0t: status expected %b actual %b", $time, want.status, status);
            end
        endfunction

        function int unsigned pending();
            return means_due.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata  = '0;          // [31:0] sample
    logic                  s_axis_tuser  = ACTION_PUSH; // [0] action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;                // [31:0] average
    logic                  m_axis_tuser;                // [0] status
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [ADDR_W-1:0]     paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bit                    tx_idle      = 1'b1;
    bit                    rx_idle      = 1'b1;
    bit                    hold_off_req = 1'b0;
    int unsigned           random_items = 0;
    int unsigned           random_means = 0;
    int unsigned           cycle_count  = 0;

    window_mean_tracker    tracker = new();

    window_tail_average_top #(
        .MAX_WINDOW (MAX_WINDOW)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item after a random gap; hold it until the transfer completes.
    // With no gap, keep tvalid high and just swap the payload.
    task automatic offer_item(input logic action, input logic [DATA_W-1:0] sample);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        s_axis_tuser  <= action;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        tracker.accept_item(action, sample);
    endtask

    // Favor the full-scale extremes so sums hit both ends of their range.
    function automatic logic [DATA_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Write the window only once the block is idle: all results taken, and
    // enough cycles gone by for trailing pushes to leave the sum pipeline.
    task automatic write_window(input logic [CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_WINDOW, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_window(value);
    endtask

    // One run: mostly enough samples to fill the window and wrap a little,
    // sometimes too few, occasionally none at all.
    task automatic random_run(input int unsigned w);
        int unsigned roll;
        int unsigned n;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            n = w + $urandom_range(0, (w < 8) ? w : 8);
        else if (roll < 9)
            n = $urandom_range(0, w - 1);
        else
            n = 0;
        repeat (n) offer_item(ACTION_PUSH, pick_sample());
        offer_item(ACTION_FINISH, $urandom());
        random_items += n + 1;
        random_means++;
    endtask

    // Result side: take results after random gaps, and on request hold off
    // for a long stretch so the block backs up into its input.
    initial
    begin : result_sink
        int unsigned gap;
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = rx_idle ? $urandom_range(0, 10) : 0;
            if (gap != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
            tracker.check_mean(m_axis_tdata, m_axis_tuser);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("window_tail_average_top: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned windows [WINDOW_KINDS] = '{1, 3, 64, 0, 8, 50, 2, 100, 16, 5, 4, 0};
        int unsigned phase;
        int unsigned runs;
        logic [CFG_W-1:0] next_window;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window of 50: an empty run and a three-sample run both come back short
        offer_item(ACTION_FINISH, $urandom());
        repeat (3) offer_item(ACTION_PUSH, pick_sample());
        offer_item(ACTION_FINISH, $urandom());

        // Window of one: the full-scale extremes pass straight through
        write_window(7'd1);
        offer_item(ACTION_PUSH, 32'h7FFF_FFFF);
        offer_item(ACTION_FINISH, 32'h0000_0000);
        offer_item(ACTION_PUSH, 32'h8000_0000);
        offer_item(ACTION_FINISH, 32'hFFFF_FFFF);

        // Zero acts as a window of one
        write_window(7'd0);
        offer_item(ACTION_PUSH, -32'sd5);
        offer_item(ACTION_FINISH, 32'h0000_0000);

        // Window of two: a negative mean truncates toward zero, then the ring wraps
        write_window(7'd2);
        offer_item(ACTION_PUSH, 32'd1);
        offer_item(ACTION_PUSH, -32'sd4);
        offer_item(ACTION_FINISH, 32'h0000_0000);
        offer_item(ACTION_PUSH, 32'd7);
        offer_item(ACTION_PUSH, 32'd8);
        offer_item(ACTION_PUSH, 32'd9);
        offer_item(ACTION_FINISH, 32'h0000_0000);
        // A finish right after a finish sees an empty run
        offer_item(ACTION_FINISH, 32'h0000_0000);

        // Rewriting the window mid-run drops the samples held so far
        offer_item(ACTION_PUSH, 32'h0000_1234);
        offer_item(ACTION_PUSH, 32'hFFFF_FFFF);
        write_window(7'd2);
        offer_item(ACTION_PUSH, 32'h0001_0000);
        offer_item(ACTION_FINISH, 32'h0000_0000);

        // Above the ring size acts as the ring size
        write_window(7'd127);
        offer_item(ACTION_FINISH, 32'h0000_0000);

        // Back-pressure: stall the result side while one-sample means keep coming
        write_window(7'd1);
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        hold_off_req = 1'b1;
        repeat (16)
        begin
            offer_item(ACTION_PUSH, pick_sample());
            offer_item(ACTION_FINISH, $urandom());
        end

        // Random runs, cycling through window settings with the idling mix varied per phase
        phase = 0;
        while (random_items < RANDOM_ITEMS || random_means < RANDOM_MEANS)
        begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if (phase % WINDOW_KINDS == WINDOW_KINDS - 1)
                next_window = CFG_W'($urandom_range(1, MAX_WINDOW));
            else
                next_window = CFG_W'(windows[phase % WINDOW_KINDS]);
            write_window(next_window);
            runs = (tracker.span() >= 32) ? 1 : 6;
            repeat (runs) random_run(tracker.span());
            phase++;
        end

        // Drain: wait out every result, then allow a late extra one to show up
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("window_tail_average_top: match");
        else
            $display("window_tail_average_top: mismatch");
        $finish;
    end

endmodule

/* files.f */
rtl/wta_pkg.sv
rtl/wta_ram.sv
rtl/wta_front.sv
rtl/wta_div.sv
rtl/wta_back.sv
rtl/window_tail_average_top.sv
rtl/wta_checker.sv
dv/tb_window_tail_average_top.sv
